@@ hdl/waist_pose_from_markers_assert.svh @@
// Assertion macros used by the checker file.
`ifndef WAIST_POSE_FROM_MARKERS_ASSERT_SVH
`define WAIST_POSE_FROM_MARKERS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WPM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("waist pose check failed");

// Next-cycle implication, checked outside reset.
`define WPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("waist pose check failed");

`endif

@@ hdl/wpm_pkg.sv @@
package wpm_pkg;

    localparam int COORD_BITS = 20;
    localparam int ANGLE_BITS = 16;
    localparam int OFFS_BITS  = 16;

    // Internal angle: 2^31 stands for pi
    localparam int ZW         = 34;
    // Vectoring datapath and normalize compare widths
    localparam int XW         = 46;
    localparam int MW         = 41;
    localparam int NORM_LIM   = 40;
    localparam int STEPS      = 31;
    // Rotation datapath (Q30)
    localparam int CW_ROT     = 34;

    localparam int ATAN_LAT   = STEPS + 4;
    localparam int COS_LAT    = STEPS + 2;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(64'sd1 <<< 31);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(64'sd1 <<< 30);
    localparam logic signed [CW_ROT-1:0] INV_GAIN = CW_ROT'(64'sd652032874);

    typedef enum logic [0:0] {
        CFG_OFFSET_X = 1'b0,
        CFG_OFFSET_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] front_up_y;
        logic signed [COORD_BITS-1:0] left_up_x;
        logic signed [COORD_BITS-1:0] left_up_y;
        logic signed [COORD_BITS-1:0] right_up_x;
        logic signed [COORD_BITS-1:0] right_up_y;
        logic signed [COORD_BITS-1:0] left_back_x;
        logic signed [COORD_BITS-1:0] left_back_y;
        logic signed [COORD_BITS-1:0] right_back_x;
        logic signed [COORD_BITS-1:0] right_back_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [ANGLE_BITS-1:0] heading;
    } t_out;

    // Arctangent of 2^-i in internal angle units
    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(64'sd536870912);
            1:       v = ZW'(64'sd316933406);
            2:       v = ZW'(64'sd167458907);
            3:       v = ZW'(64'sd85004756);
            4:       v = ZW'(64'sd42667331);
            5:       v = ZW'(64'sd21354465);
            6:       v = ZW'(64'sd10679838);
            7:       v = ZW'(64'sd5340245);
            8:       v = ZW'(64'sd2670163);
            9:       v = ZW'(64'sd1335087);
            10:      v = ZW'(64'sd667544);
            11:      v = ZW'(64'sd333772);
            12:      v = ZW'(64'sd166886);
            13:      v = ZW'(64'sd83443);
            14:      v = ZW'(64'sd41722);
            15:      v = ZW'(64'sd20861);
            16:      v = ZW'(64'sd10430);
            17:      v = ZW'(64'sd5215);
            18:      v = ZW'(64'sd2608);
            19:      v = ZW'(64'sd1304);
            20:      v = ZW'(64'sd652);
            21:      v = ZW'(64'sd326);
            22:      v = ZW'(64'sd163);
            23:      v = ZW'(64'sd81);
            24:      v = ZW'(64'sd41);
            25:      v = ZW'(64'sd20);
            26:      v = ZW'(64'sd10);
            27:      v = ZW'(64'sd5);
            28:      v = ZW'(64'sd3);
            29:      v = ZW'(64'sd1);
            30:      v = ZW'(64'sd1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/wpm_atan.sv @@
module wpm_atan (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic signed [wpm_pkg::COORD_BITS:0]  i_dx,
    input  logic signed [wpm_pkg::COORD_BITS:0]  i_dy,
    output logic                                 o_vld,
    output logic signed [wpm_pkg::ZW-1:0]        o_z
);
    import wpm_pkg::*;

    localparam int NST = STEPS + 3;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic        [MW-1:0] m;
        logic                 sp;
        logic signed [ZW-1:0] spz;
    } t_vec;

    // Shift up by sh while the magnitude stays below the limit
    function automatic t_vec norm_step(input t_vec v, input int sh);
        t_vec r;
        r = v;
        if ((v.m >> (NORM_LIM - sh)) == '0) begin
            r.m = v.m << sh;
            r.x = v.x <<< sh;
            r.y = v.y <<< sh;
        end
        return r;
    endfunction

    // One vectoring micro-rotation
    function automatic t_vec rot(input t_vec v, input int i);
        t_vec r;
        r = v;
        if (!v.y[XW-1]) begin
            r.x = v.x + (v.y >>> i);
            r.y = v.y - (v.x >>> i);
            r.z = v.z + atan_val(i);
        end else begin
            r.x = v.x - (v.y >>> i);
            r.y = v.y + (v.x >>> i);
            r.z = v.z - atan_val(i);
        end
        return r;
    endfunction

    t_vec                  r_p [NST];
    logic [NST:0]          r_v;
    logic signed [ZW-1:0]  r_z;
    t_vec                  n_fold;
    t_vec                  n_na;
    t_vec                  n_nb;
    logic signed [XW-1:0]  w_dx;
    logic signed [XW-1:0]  w_dy;
    logic signed [ZW-1:0]  w_zc;

    // Fold into the right half plane, flag the horizontal case
    always_comb begin
        w_dx = XW'(i_dx);
        w_dy = XW'(i_dy);
        n_fold = '0;
        n_fold.sp  = (i_dy == '0);
        n_fold.spz = (i_dx > 0) ? '0 : PI_Z;
        if (i_dx < 0) begin
            n_fold.x = -w_dx;
            n_fold.y = -w_dy;
            n_fold.z = (i_dy > 0) ? PI_Z : -PI_Z;
        end else begin
            n_fold.x = w_dx;
            n_fold.y = w_dy;
            n_fold.z = '0;
        end
        if (n_fold.y < 0) begin
            n_fold.m = (n_fold.x > -n_fold.y) ? MW'(n_fold.x) : MW'(-n_fold.y);
        end else begin
            n_fold.m = (n_fold.x > n_fold.y) ? MW'(n_fold.x) : MW'(n_fold.y);
        end
    end

    // Normalize in two stages, then one more doubling
    always_comb begin
        n_na = norm_step(r_p[0], 32);
        n_na = norm_step(n_na, 16);
        n_na = norm_step(n_na, 8);
        n_nb = norm_step(r_p[1], 4);
        n_nb = norm_step(n_nb, 2);
        n_nb = norm_step(n_nb, 1);
        n_nb.x = n_nb.x <<< 1;
        n_nb.y = n_nb.y <<< 1;
        n_nb.m = n_nb.m << 1;
    end

    // Clamp, or take the exact horizontal angle
    always_comb begin
        w_zc = r_p[NST-1].z;
        if (w_zc > PI_Z) begin
            w_zc = PI_Z;
        end
        if (w_zc <= -PI_Z) begin
            w_zc = -PI_Z + ZW'(1);
        end
        if (r_p[NST-1].sp) begin
            w_zc = r_p[NST-1].spz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= n_fold;
            r_p[1] <= n_na;
            r_p[2] <= n_nb;
            r_z    <= w_zc;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[g+3] <= rot(r_p[g+2], g);
            end
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-1:0], i_vld};
        end
    end

    assign o_vld = r_v[NST];
    assign o_z   = r_z;

endmodule

@@ hdl/wpm_cos.sv @@
module wpm_cos (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  logic signed [wpm_pkg::ZW-1:0]        i_a,
    output logic                                 o_vld,
    output logic signed [wpm_pkg::CW_ROT-1:0]    o_c
);
    import wpm_pkg::*;

    localparam int NST = STEPS + 1;

    typedef struct packed {
        logic signed [CW_ROT-1:0] x;
        logic signed [CW_ROT-1:0] y;
        logic signed [ZW-1:0]     z;
        logic                     neg;
    } t_rot;

    // One rotation-mode micro-rotation
    function automatic t_rot rot(input t_rot v, input int i);
        t_rot r;
        r = v;
        if (!v.z[ZW-1]) begin
            r.x = v.x - (v.y >>> i);
            r.y = v.y + (v.x >>> i);
            r.z = v.z - atan_val(i);
        end else begin
            r.x = v.x + (v.y >>> i);
            r.y = v.y - (v.x >>> i);
            r.z = v.z + atan_val(i);
        end
        return r;
    endfunction

    t_rot                      r_p [NST];
    logic [NST:0]              r_v;
    logic signed [CW_ROT-1:0]  r_c;
    t_rot                      n_fold;
    logic signed [ZW-1:0]      w_abs;

    // Fold the angle into the first quadrant
    always_comb begin
        w_abs = (i_a < 0) ? -i_a : i_a;
        n_fold.x   = INV_GAIN;
        n_fold.y   = '0;
        n_fold.neg = (w_abs > HALF_PI_Z);
        n_fold.z   = n_fold.neg ? (PI_Z - w_abs) : w_abs;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= n_fold;
            r_c    <= r_p[NST-1].neg ? -r_p[NST-1].x : r_p[NST-1].x;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[g+1] <= rot(r_p[g], g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-1:0], i_vld};
        end
    end

    assign o_vld = r_v[NST];
    assign o_c   = r_c;

endmodule

@@ hdl/waist_pose_from_markers.sv @@
// Planar waist pose from one marker frame: heading is the mean of the left and right
// up-minus-back bearings, origin is the marker coordinate plus offset times cos(heading).
// One frame is taken every cycle while o_stall is low; the result comes from two
// 31-step CORDIC pipelines (bearing, then cosine) in series. A frame whose
// left or right marker pair coincides in x and y gives no result.
module waist_pose_from_markers (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  wpm_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output wpm_pkg::t_out                  o_data,
    input  logic                           i_cfg_we,
    input  wpm_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [wpm_pkg::OFFS_BITS-1:0]  i_cfg_data
);
    import wpm_pkg::*;

    localparam int DW      = COORD_BITS + 1;
    localparam int PW      = OFFS_BITS + 1 + CW_ROT;
    localparam int HEAD_SH = 32 - ANGLE_BITS;

    localparam logic signed [ZW-1:0] HEAD_RND = ZW'(64'sd1 <<< (HEAD_SH - 1));
    localparam logic signed [ZW-1:0] HEAD_MAX = ZW'((64'sd1 <<< (ANGLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ZW-1:0] HEAD_MIN = -HEAD_MAX - ZW'(1);
    localparam logic signed [PW-1:0] PRD_RND  = PW'(64'sd1 <<< 29);
    localparam logic signed [PW-1:0] CRD_MAX  = PW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] CRD_MIN  = -CRD_MAX - PW'(1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] lux;
        logic signed [COORD_BITS-1:0] fuy;
        logic                         degen;
    } t_sb;

    typedef struct packed {
        t_sb                          sb;
        logic signed [ANGLE_BITS-1:0] head;
    } t_sb2;

    logic                       w_en;
    logic [OFFS_BITS-1:0]       r_off_x;
    logic [OFFS_BITS-1:0]       r_off_y;

    logic                       r_s0_vld;
    logic signed [DW-1:0]       r_ldx, r_ldy, r_rdx, r_rdy;
    t_sb                        r_s0_sb;
    logic signed [DW-1:0]       n_ldx, n_ldy, n_rdx, n_rdy;

    logic                       w_a_vld;
    logic                       w_b_vld;
    logic signed [ZW-1:0]       w_a1, w_a2;
    t_sb                        r_sb_a [ATAN_LAT];

    logic                       r_m_vld;
    logic signed [ZW-1:0]       r_mean;
    t_sb2                       r_m_sb;
    logic signed [ZW:0]         w_sum;
    logic signed [ZW-1:0]       w_mean;
    logic signed [ZW-1:0]       w_hs;
    logic signed [ANGLE_BITS-1:0] w_head;

    logic                       w_c_vld;
    logic signed [CW_ROT-1:0]   w_c;
    t_sb2                       r_sb_c [COS_LAT];

    logic                       r_p_vld;
    logic signed [PW-1:0]       r_px, r_py;
    t_sb2                       r_p_sb;

    logic                       r_o_vld;
    t_out                       r_o_data;
    logic signed [PW-1:0]       w_ox, w_oy;
    logic signed [COORD_BITS-1:0] w_sx, w_sy;

    // The whole pipeline holds only while a finished result waits
    assign w_en    = !(r_o_vld && i_stall);
    assign o_stall = r_o_vld && i_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= OFFS_BITS'(2000);
            r_off_y <= OFFS_BITS'(2400);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_X: r_off_x <= i_cfg_data;
                CFG_OFFSET_Y: r_off_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage: marker pair differences
    always_comb begin
        n_ldx = DW'(i_data.left_up_x) - DW'(i_data.left_back_x);
        n_ldy = DW'(i_data.left_up_y) - DW'(i_data.left_back_y);
        n_rdx = DW'(i_data.right_up_x) - DW'(i_data.right_back_x);
        n_rdy = DW'(i_data.right_up_y) - DW'(i_data.right_back_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ldx <= n_ldx;
            r_ldy <= n_ldy;
            r_rdx <= n_rdx;
            r_rdy <= n_rdy;
            r_s0_sb.lux   <= i_data.left_up_x;
            r_s0_sb.fuy   <= i_data.front_up_y;
            r_s0_sb.degen <= ((n_ldx == '0) && (n_ldy == '0)) ||
                             ((n_rdx == '0) && (n_rdy == '0));
        end
    end

    wpm_atan u_atan_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_dx    (r_ldx),
        .i_dy    (r_ldy),
        .o_vld   (w_a_vld),
        .o_z     (w_a1)
    );

    wpm_atan u_atan_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_dx    (r_rdx),
        .i_dy    (r_rdy),
        .o_vld   (w_b_vld),
        .o_z     (w_a2)
    );

    // Mean bearing and rounded heading
    always_comb begin
        w_sum  = (ZW+1)'(w_a1) + (ZW+1)'(w_a2);
        w_mean = ZW'(w_sum >>> 1);
        w_hs   = (w_mean + HEAD_RND) >>> HEAD_SH;
        if (w_hs > HEAD_MAX) begin
            w_head = ANGLE_BITS'(HEAD_MAX);
        end else if (w_hs < HEAD_MIN) begin
            w_head = ANGLE_BITS'(HEAD_MIN);
        end else begin
            w_head = ANGLE_BITS'(w_hs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_a[0] <= r_s0_sb;
            for (int k = 1; k < ATAN_LAT; k++) begin
                r_sb_a[k] <= r_sb_a[k-1];
            end
            r_mean      <= w_mean;
            r_m_sb.sb   <= r_sb_a[ATAN_LAT-1];
            r_m_sb.head <= w_head;
        end
    end

    wpm_cos u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_m_vld),
        .i_a     (r_mean),
        .o_vld   (w_c_vld),
        .o_c     (w_c)
    );

    // Offset products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_c[0] <= r_m_sb;
            for (int k = 1; k < COS_LAT; k++) begin
                r_sb_c[k] <= r_sb_c[k-1];
            end
            r_px   <= $signed({1'b0, r_off_x}) * w_c;
            r_py   <= $signed({1'b0, r_off_y}) * w_c;
            r_p_sb <= r_sb_c[COS_LAT-1];
        end
    end

    // Round, add to the marker coordinate, saturate
    always_comb begin
        w_ox = ((r_px + PRD_RND) >>> 30) + PW'(r_p_sb.sb.lux);
        w_oy = ((r_py + PRD_RND) >>> 30) + PW'(r_p_sb.sb.fuy);
        if (w_ox > CRD_MAX) begin
            w_sx = COORD_BITS'(CRD_MAX);
        end else if (w_ox < CRD_MIN) begin
            w_sx = COORD_BITS'(CRD_MIN);
        end else begin
            w_sx = COORD_BITS'(w_ox);
        end
        if (w_oy > CRD_MAX) begin
            w_sy = COORD_BITS'(CRD_MAX);
        end else if (w_oy < CRD_MIN) begin
            w_sy = COORD_BITS'(CRD_MIN);
        end else begin
            w_sy = COORD_BITS'(w_oy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data.origin_x <= w_sx;
            r_o_data.origin_y <= w_sy;
            r_o_data.heading  <= r_p_sb.head;
        end
    end

    // Valid bits; drop frames with a degenerate marker pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_m_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_valid;
            r_m_vld  <= w_a_vld && w_b_vld;
            r_p_vld  <= w_c_vld;
            r_o_vld  <= r_p_vld && !r_p_sb.sb.degen;
        end
    end

    assign o_valid = r_o_vld;
    assign o_data  = r_o_data;

endmodule

@@ hdl/wpm_checker.sv @@
`include "waist_pose_from_markers_assert.svh"

module wpm_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_stall,
    input  logic           o_valid,
    input  logic           i_stall,
    input  wpm_pkg::t_out  o_data
);
    import wpm_pkg::*;

    // A held result stays offered
    `WPM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    // A held result keeps its value
    `WPM_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_data))
    // Input is held back only while a result waits
    `WPM_ASSERT_IMPL(a_stall_cause, o_stall, o_valid && i_stall)
    // Nothing comes out right after reset
    `WPM_ASSERT_IMPL(a_reset_empty, $past(!i_rst_n), !o_valid)

endmodule

bind waist_pose_from_markers wpm_checker u_wpm_checker (.*);
